FILE: design/clock_seven_segment_formatter_macros.svh
// Assertion macros for the clock segment formatter.
// The design that uses them must have clk and arst_n in scope.
`ifndef CLOCK_SEVEN_SEGMENT_FORMATTER_MACROS_SVH
`define CLOCK_SEVEN_SEGMENT_FORMATTER_MACROS_SVH
`ifndef ASSERT_OFF
`define CCSF_ASSERT_SAME(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("same-cycle check failed");
`define CCSF_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("next-cycle check failed");
`else
`define CCSF_ASSERT_SAME(label, cond, expr)
`define CCSF_ASSERT_NEXT(label, cond, expr)
`endif
`endif

FILE: design/ccsf_pkg.sv
package ccsf_pkg;

	localparam logic [1:0] OP_TIME  = 2'd0;
	localparam logic [1:0] OP_DATE  = 2'd1;
	localparam logic [1:0] OP_WATCH = 2'd2;
	localparam logic [1:0] OP_WORLD = 2'd3;

	localparam logic [16:0] TIME_MAX    = 17'd86399;
	localparam logic [16:0] WATCH_MAX   = 17'd59999;
	localparam logic [17:0] DAY_SECONDS = 18'd86400;
	localparam logic [6:0]  YEAR_MAX    = 7'd99;
	localparam logic [3:0]  MONTH_MAX   = 4'd12;

	// Quotient = (value * reciprocal) >> shift, exact over the saturated input ranges.
	localparam logic [18:0] RECIP_HOUR     = 19'd74566;
	localparam logic [18:0] RECIP_TEN_MIN  = 19'd447393;
	localparam int          RECIP_SHIFT    = 28;
	localparam logic [12:0] RECIP_MIN      = 13'd4370;
	localparam logic [12:0] RECIP_HUNDRED  = 13'd2622;
	localparam int          RECIP_SHIFT_LO = 18;

	localparam logic [11:0] HOUR_SECONDS   = 12'd3600;
	localparam logic [11:0] TEN_MIN_TENTHS = 12'd600;
	localparam logic [6:0]  MIN_SECONDS    = 7'd60;
	localparam logic [6:0]  SEC_TENTHS     = 7'd100;
	localparam logic [6:0]  QUOT_LIMIT     = 7'd100;
	localparam logic [7:0]  SEP_BYTE       = 8'h08;

	typedef struct packed {
		logic [1:0]  op;
		logic [16:0] tv;
		logic [2:0]  zone;
		logic [6:0]  yr;
		logic [3:0]  mo;
		logic [4:0]  dy;
	} req_t;

	typedef struct packed {
		logic [3:0] yr_t;
		logic [3:0] yr_u;
		logic [3:0] mo_t;
		logic [3:0] mo_u;
		logic [3:0] dy_t;
		logic [3:0] dy_u;
	} date_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [16:0] v;
		date_t       date;
	} prep_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [6:0]  q;
		logic [11:0] a;
		logic [6:0]  b;
		date_t       date;
	} split_t;

	function automatic logic [6:0] seg_code(input logic [3:0] d);
		logic [6:0] code;
		unique case (d)
			4'd0: code = 7'h3F;
			4'd1: code = 7'h06;
			4'd2: code = 7'h5B;
			4'd3: code = 7'h4F;
			4'd4: code = 7'h66;
			4'd5: code = 7'h6D;
			4'd6: code = 7'h7D;
			4'd7: code = 7'h07;
			4'd8: code = 7'h7F;
			4'd9: code = 7'h67;
			default: code = 7'h00;
		endcase
		return code;
	endfunction

	function automatic logic [16:0] zone_offset(input logic [2:0] z);
		logic [16:0] off;
		case (z)
			3'd0: off = 17'd0;
			3'd1: off = 17'd82800;
			3'd2: off = 17'd64800;
			3'd3: off = 17'd57600;
			3'd4: off = 17'd36000;
			default: off = 17'd25200;
		endcase
		return off;
	endfunction

	// Tens and units of a value below 100.
	function automatic logic [7:0] to_bcd(input logic [6:0] x);
		logic [3:0] tens;
		logic [6:0] units;
		tens  = 4'd0;
		units = x;
		for (int i = 1; i < 10; i++) begin
			if (x >= 7'(10 * i)) begin
				tens  = 4'(i);
				units = x - 7'(10 * i);
			end
		end
		return {tens, units[3:0]};
	endfunction

	function automatic logic [14:0] pair_word(input logic [6:0] x);
		logic [7:0] bcd;
		bcd = to_bcd(x);
		return {seg_code(bcd[7:4]), 1'b0, seg_code(bcd[3:0])};
	endfunction

endpackage

FILE: design/ccsf_prep.sv
module ccsf_prep (
	input  logic            clk,
	input  logic            en,
	input  ccsf_pkg::req_t  req_s1,
	output ccsf_pkg::prep_t prep_s2
);
	import ccsf_pkg::*;

	logic [16:0] tv_day;
	logic [16:0] tv_watch;
	logic [17:0] shifted;
	logic [16:0] world;
	logic [6:0]  yr_sat;
	logic [3:0]  mo_sat;
	logic [7:0]  yr_bcd;
	logic [7:0]  mo_bcd;
	logic [7:0]  dy_bcd;
	prep_t       prep_d;

	always_comb begin
		tv_day   = (req_s1.tv > TIME_MAX) ? TIME_MAX : req_s1.tv;
		tv_watch = (req_s1.tv > WATCH_MAX) ? WATCH_MAX : req_s1.tv;
		shifted  = {1'b0, tv_day} + {1'b0, zone_offset(req_s1.zone)};
		world    = (shifted >= DAY_SECONDS) ? 17'(shifted - DAY_SECONDS) : shifted[16:0];
		yr_sat   = (req_s1.yr > YEAR_MAX) ? YEAR_MAX : req_s1.yr;
		mo_sat   = (req_s1.mo > MONTH_MAX) ? MONTH_MAX : req_s1.mo;
		yr_bcd   = to_bcd(yr_sat);
		mo_bcd   = to_bcd({3'b000, mo_sat});
		dy_bcd   = to_bcd({2'b00, req_s1.dy});

		prep_d.date.yr_t = yr_bcd[7:4];
		prep_d.date.yr_u = yr_bcd[3:0];
		prep_d.date.mo_t = mo_bcd[7:4];
		prep_d.date.mo_u = mo_bcd[3:0];
		prep_d.date.dy_t = dy_bcd[7:4];
		prep_d.date.dy_u = dy_bcd[3:0];

		case (req_s1.op)
			OP_DATE: begin
				prep_d.mode = OP_DATE;
				prep_d.v    = '0;
			end
			OP_WATCH: begin
				prep_d.mode = OP_WATCH;
				prep_d.v    = tv_watch;
			end
			OP_WORLD: begin
				prep_d.mode = OP_TIME;
				prep_d.v    = world;
			end
			default: begin
				prep_d.mode = OP_TIME;
				prep_d.v    = tv_day;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s2 <= prep_d;
		end
	end

endmodule

FILE: design/ccsf_divide.sv
module ccsf_divide (
	input  logic             clk,
	input  logic             en,
	input  ccsf_pkg::prep_t  prep_s2,
	output ccsf_pkg::split_t split_s5
);
	import ccsf_pkg::*;

	logic [18:0] recip_hi;
	logic [35:0] prod_hi;
	logic [1:0]  mode_s3;
	logic [16:0] v_s3;
	logic [6:0]  q_s3;
	date_t       date_s3;

	logic [11:0] div_hi;
	logic [18:0] back_hi;
	logic [16:0] rem_hi;
	logic [1:0]  mode_s4;
	logic [6:0]  q_s4;
	logic [11:0] a_s4;
	date_t       date_s4;

	logic [12:0] recip_lo;
	logic [24:0] prod_lo;

	always_comb begin
		recip_hi = (prep_s2.mode == OP_WATCH) ? RECIP_TEN_MIN : RECIP_HOUR;
		prod_hi  = {19'b0, prep_s2.v} * {17'b0, recip_hi};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3 <= prep_s2.mode;
			v_s3    <= prep_s2.v;
			q_s3    <= prod_hi[RECIP_SHIFT +: 7];
			date_s3 <= prep_s2.date;
		end
	end

	always_comb begin
		div_hi  = (mode_s3 == OP_WATCH) ? TEN_MIN_TENTHS : HOUR_SECONDS;
		back_hi = {12'b0, q_s3} * {7'b0, div_hi};
		rem_hi  = v_s3 - back_hi[16:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s4 <= mode_s3;
			q_s4    <= q_s3;
			a_s4    <= rem_hi[11:0];
			date_s4 <= date_s3;
		end
	end

	always_comb begin
		recip_lo = (mode_s4 == OP_WATCH) ? RECIP_HUNDRED : RECIP_MIN;
		prod_lo  = {13'b0, a_s4} * {12'b0, recip_lo};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			split_s5.mode <= mode_s4;
			split_s5.q    <= q_s4;
			split_s5.a    <= a_s4;
			split_s5.b    <= prod_lo[RECIP_SHIFT_LO +: 7];
			split_s5.date <= date_s4;
		end
	end

endmodule

FILE: design/ccsf_pack.sv
module ccsf_pack (
	input  logic             clk,
	input  logic             en,
	input  ccsf_pkg::split_t split_s5,
	output logic [30:0]      low_q,
	output logic [14:0]      high_q
);
	import ccsf_pkg::*;

	logic [6:0]  div_lo;
	logic [13:0] back_lo;
	logic [11:0] rem_lo;
	logic [6:0]  c;
	logic [14:0] q_pair;
	logic [14:0] b_pair;
	logic [14:0] c_pair;
	logic [30:0] low_d;
	logic [14:0] high_d;

	always_comb begin
		div_lo  = (split_s5.mode == OP_WATCH) ? SEC_TENTHS : MIN_SECONDS;
		back_lo = {7'b0, split_s5.b} * {7'b0, div_lo};
		rem_lo  = split_s5.a - back_lo[11:0];
		c       = rem_lo[6:0];
		q_pair  = pair_word(split_s5.q);
		b_pair  = pair_word(split_s5.b);
		c_pair  = pair_word(c);

		case (split_s5.mode)
			OP_DATE: begin
				high_d = {seg_code(split_s5.date.yr_t), 1'b0, seg_code(split_s5.date.yr_u)};
				low_d  = {seg_code(split_s5.date.mo_t), 1'b0, seg_code(split_s5.date.mo_u),
					1'b0, seg_code(split_s5.date.dy_t), 1'b0, seg_code(split_s5.date.dy_u)};
			end
			OP_WATCH: begin
				high_d = q_pair;
				low_d  = {seg_code(split_s5.b[3:0]), 1'b0, c_pair[14:8], SEP_BYTE, c_pair[7:0]};
			end
			default: begin
				high_d = q_pair;
				low_d  = {b_pair, 1'b0, c_pair};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			low_q  <= low_d;
			high_q <= high_d;
		end
	end

endmodule

FILE: design/clock_seven_segment_formatter.sv
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  opcode, time_value, zone_select, year_two_digit,
//                                           month_number, day_number
// result    out        out_valid/out_stall  low_digits_word, high_digits_word
//
// One request is taken every cycle while in_stall is low.
// The six register stages are the input register, the prep stage, three divide stages
// and the output register.
// Reset clears only the stage valid bits.
// A stalled result freezes the whole pipeline, and in_stall follows at once.
`include "clock_seven_segment_formatter_macros.svh"

module clock_seven_segment_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [16:0] time_value,
	input  logic [2:0]  zone_select,
	input  logic [6:0]  year_two_digit,
	input  logic [3:0]  month_number,
	input  logic [4:0]  day_number,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [30:0] low_digits_word,
	output logic [14:0] high_digits_word
);
	import ccsf_pkg::*;

	logic   adv;
	logic   valid_s1;
	logic   valid_s2;
	logic   valid_s3;
	logic   valid_s4;
	logic   valid_s5;
	logic   out_valid_q;
	req_t   req_s1;
	prep_t  prep_s2;
	split_t split_s5;

	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			out_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1.op   <= opcode;
			req_s1.tv   <= time_value;
			req_s1.zone <= zone_select;
			req_s1.yr   <= year_two_digit;
			req_s1.mo   <= month_number;
			req_s1.dy   <= day_number;
		end
	end

	ccsf_prep u_prep (
		.clk     (clk),
		.en      (adv),
		.req_s1  (req_s1),
		.prep_s2 (prep_s2)
	);

	ccsf_divide u_divide (
		.clk      (clk),
		.en       (adv),
		.prep_s2  (prep_s2),
		.split_s5 (split_s5)
	);

	ccsf_pack u_pack (
		.clk      (clk),
		.en       (adv),
		.split_s5 (split_s5),
		.low_q    (low_digits_word),
		.high_q   (high_digits_word)
	);

	`CCSF_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, valid_s1)
	`CCSF_ASSERT_NEXT(a_freeze_on_stall, out_valid && out_stall,
		$stable({valid_s1, valid_s2, valid_s3, valid_s4, valid_s5}))
	`CCSF_ASSERT_SAME(a_quotient_range, valid_s5,
		split_s5.q < QUOT_LIMIT && split_s5.a < HOUR_SECONDS && split_s5.b < MIN_SECONDS)

endmodule

FILE: test/tb_clock_seven_segment_formatter.sv
module tb_clock_seven_segment_formatter;
	import ccsf_pkg::*;

	typedef struct packed {
		logic [30:0] lo;
		logic [14:0] hi;
	} digits_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [16:0] tv;
		logic [2:0]  zone;
		logic [6:0]  yr;
		logic [3:0]  mo;
		logic [4:0]  dy;
		bit          known;
		logic [30:0] lo;
		logic [14:0] hi;
	} vector_t;

	localparam logic [7:0] SEPARATOR = 8'h08;
	localparam int RANDOM_REQUESTS = 1850;
	localparam int DIRECTED_COUNT = 23;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = OP_TIME;
	logic [16:0] time_value = '0;
	logic [2:0]  zone_select = '0;
	logic [6:0]  year_two_digit = '0;
	logic [3:0]  month_number = '0;
	logic [4:0]  day_number = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [30:0] low_digits_word;
	logic [14:0] high_digits_word;

	digits_t pending_digits[$];
	int      errors = 0;
	bit      calm_in = 1'b0;
	bit      calm_out = 1'b0;
	int      stall_left = 0;
	int      sink_cycles = 0;

	byte unsigned seg_pattern [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
		8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67};
	int unsigned zone_hours [6] = '{0, 23, 18, 16, 10, 7};

	vector_t directed_vectors [DIRECTED_COUNT] = '{
		'{OP_TIME,  17'd0,      3'd0, 7'd0,   4'd0,  5'd0,  1'b1, 31'h3F3F3F3F, 15'h3F3F},
		'{OP_TIME,  17'd86399,  3'd7, 7'd127, 4'd15, 5'd31, 1'b1, 31'h6D676D67, 15'h5B4F},
		'{OP_TIME,  17'h1FFFF,  3'd0, 7'd0,   4'd0,  5'd0,  1'b1, 31'h6D676D67, 15'h5B4F},
		'{OP_TIME,  17'd86400,  3'd2, 7'd5,   4'd3,  5'd9,  1'b1, 31'h6D676D67, 15'h5B4F},
		'{OP_TIME,  17'd3661,   3'd7, 7'd127, 4'd15, 5'd31, 1'b0, 31'h0,        15'h0},
		'{OP_DATE,  17'd0,      3'd0, 7'd0,   4'd0,  5'd0,  1'b1, 31'h3F3F3F3F, 15'h3F3F},
		'{OP_DATE,  17'h1FFFF,  3'd7, 7'd99,  4'd12, 5'd31, 1'b1, 31'h065B4F06, 15'h6767},
		'{OP_DATE,  17'd0,      3'd0, 7'd127, 4'd15, 5'd31, 1'b1, 31'h065B4F06, 15'h6767},
		'{OP_DATE,  17'd12345,  3'd3, 7'd26,  4'd2,  5'd29, 1'b0, 31'h0,        15'h0},
		'{OP_WATCH, 17'd0,      3'd0, 7'd0,   4'd0,  5'd0,  1'b1, 31'h3F3F083F, 15'h3F3F},
		'{OP_WATCH, 17'd59999,  3'd5, 7'd99,  4'd9,  5'd1,  1'b1, 31'h6D670867, 15'h6767},
		'{OP_WATCH, 17'h1FFFF,  3'd7, 7'd127, 4'd15, 5'd31, 1'b1, 31'h6D670867, 15'h6767},
		'{OP_WATCH, 17'd60000,  3'd0, 7'd0,   4'd0,  5'd0,  1'b1, 31'h6D670867, 15'h6767},
		'{OP_WORLD, 17'd0,      3'd0, 7'd0,   4'd0,  5'd0,  1'b1, 31'h3F3F3F3F, 15'h3F3F},
		'{OP_WORLD, 17'd0,      3'd1, 7'd0,   4'd0,  5'd0,  1'b1, 31'h3F3F3F3F, 15'h5B4F},
		'{OP_WORLD, 17'd0,      3'd2, 7'd0,   4'd0,  5'd0,  1'b1, 31'h3F3F3F3F, 15'h067F},
		'{OP_WORLD, 17'd0,      3'd3, 7'd0,   4'd0,  5'd0,  1'b1, 31'h3F3F3F3F, 15'h067D},
		'{OP_WORLD, 17'd0,      3'd4, 7'd0,   4'd0,  5'd0,  1'b1, 31'h3F3F3F3F, 15'h063F},
		'{OP_WORLD, 17'd0,      3'd5, 7'd0,   4'd0,  5'd0,  1'b1, 31'h3F3F3F3F, 15'h3F07},
		'{OP_WORLD, 17'd0,      3'd6, 7'd0,   4'd0,  5'd0,  1'b1, 31'h3F3F3F3F, 15'h3F07},
		'{OP_WORLD, 17'd0,      3'd7, 7'd0,   4'd0,  5'd0,  1'b1, 31'h3F3F3F3F, 15'h3F07},
		'{OP_WORLD, 17'd86399,  3'd1, 7'd127, 4'd15, 5'd31, 1'b0, 31'h0,        15'h0},
		'{OP_WORLD, 17'h1FFFF,  3'd7, 7'd0,   4'd0,  5'd0,  1'b0, 31'h0,        15'h0}
	};

	clock_seven_segment_formatter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.time_value(time_value),
		.zone_select(zone_select),
		.year_two_digit(year_two_digit),
		.month_number(month_number),
		.day_number(day_number),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.low_digits_word(low_digits_word),
		.high_digits_word(high_digits_word)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] segment_code(input int unsigned d);
		return (d < 10) ? seg_pattern[d] : 8'h00;
	endfunction

	function automatic logic [15:0] two_digit_codes(input int unsigned v);
		return {segment_code(v / 10), segment_code(v % 10)};
	endfunction

	function automatic digits_t format_digits(input vector_t v);
		int unsigned t;
		int unsigned z;
		int unsigned y;
		int unsigned m;
		int unsigned md;
		int unsigned a;
		logic [31:0] lo_word;
		logic [15:0] hi_word;
		digits_t     r;
		case (v.op)
			OP_DATE: begin
				y = (v.yr > YEAR_MAX) ? YEAR_MAX : v.yr;
				m = (v.mo > MONTH_MAX) ? MONTH_MAX : v.mo;
				md = m * 100 + v.dy;
				lo_word = {segment_code(md / 1000), segment_code((md % 1000) / 100),
					segment_code((md % 100) / 10), segment_code(md % 10)};
				hi_word = two_digit_codes(y);
			end
			OP_WATCH: begin
				t = (v.tv > WATCH_MAX) ? WATCH_MAX : v.tv;
				a = t % 600;
				lo_word = {segment_code(a / 100), segment_code((a % 100) / 10),
					SEPARATOR, segment_code(a % 10)};
				hi_word = two_digit_codes(t / 600);
			end
			default: begin
				t = (v.tv > TIME_MAX) ? TIME_MAX : v.tv;
				if (v.op == OP_WORLD) begin
					z = (v.zone > 5) ? 5 : v.zone;
					t = (t + zone_hours[z] * 3600) % 86400;
				end
				a = t % 3600;
				lo_word = {segment_code(a / 600), segment_code((a % 600) / 60),
					segment_code((a % 60) / 10), segment_code(a % 10)};
				hi_word = two_digit_codes(t / 3600);
			end
		endcase
		r.lo = lo_word[30:0];
		r.hi = hi_word[14:0];
		return r;
	endfunction

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_request(input vector_t v);
		int      gap;
		digits_t want;
		gap = pick_gap(calm_in);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= v.op;
		time_value <= v.tv;
		zone_select <= v.zone;
		year_two_digit <= v.yr;
		month_number <= v.mo;
		day_number <= v.dy;
		if (v.known) begin
			want.lo = v.lo;
			want.hi = v.hi;
		end else begin
			want = format_digits(v);
		end
		do @(posedge clk); while (in_stall);
		pending_digits.push_back(want);
	endtask

	function automatic vector_t random_request();
		vector_t v;
		int      pick;
		v = '0;
		v.op = 2'($urandom_range(0, 3));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			v.tv = 17'($urandom());
		else if (pick == 1)
			v.tv = (v.op == OP_WATCH) ? 17'($urandom_range(59990, 60010))
				: 17'($urandom_range(86390, 86410));
		else
			v.tv = (v.op == OP_WATCH) ? 17'($urandom_range(0, 59999))
				: 17'($urandom_range(0, 86399));
		v.zone = 3'($urandom());
		v.yr = ($urandom_range(0, 7) == 0) ? 7'($urandom()) : 7'($urandom_range(0, 99));
		v.mo = ($urandom_range(0, 7) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 12));
		v.dy = 5'($urandom());
		return v;
	endfunction

	// The sink stalls in bursts, with quiet stretches where every result is taken at once.
	always @(posedge clk) begin
		sink_cycles++;
		if (sink_cycles % 200 == 0)
			calm_out = ($urandom_range(0, 3) == 0);
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_gap(calm_out);
		end
	end

	always @(posedge clk) begin
		digits_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_digits.size() == 0) begin
				$display("%0t unexpected transfer: low %h high %h", $time,
					low_digits_word, high_digits_word);
				errors++;
			end else begin
				want = pending_digits.pop_front();
				if (low_digits_word !== want.lo) begin
					$display("%0t low_digits_word expected %h got %h", $time,
						want.lo, low_digits_word);
					errors++;
				end
				if (high_digits_word !== want.hi) begin
					$display("%0t high_digits_word expected %h got %h", $time,
						want.hi, high_digits_word);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIRECTED_COUNT; i++)
			send_request(directed_vectors[i]);
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 150 == 0)
				calm_in = ($urandom_range(0, 3) == 0);
			send_request(random_request());
		end
		in_valid <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (errors == 0 && pending_digits.size() == 0)
			$display("clock_seven_segment_formatter: match");
		else
			$display("clock_seven_segment_formatter: mismatch");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("clock_seven_segment_formatter: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/ccsf_pkg.sv
design/ccsf_prep.sv
design/ccsf_divide.sv
design/ccsf_pack.sv
design/clock_seven_segment_formatter.sv
test/tb_clock_seven_segment_formatter.sv
